[sv/tlma_pkg.sv]
// shared types and constants for the ternary lut matvec accumulator
// no dependencies; imported by every module of the block
`default_nettype none
package tlma_pkg;

  localparam int COLUMNS_DEF = 1024;
  localparam int COL_W       = 10;
  localparam int ACT_W       = 8;
  localparam int CODE_W      = 5;
  localparam int SUM_W       = 32;
  localparam int VAL_W       = ACT_W + 1;
  localparam int TBL_ENTRIES = 14;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_ACT = 1'b0;
  localparam logic KIND_WGT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [ACT_W-1:0]  act_first;
    logic signed [ACT_W-1:0]  act_second;
    logic signed [ACT_W-1:0]  act_third;
    logic        [CODE_W-1:0] weight_code;
    logic        [COL_W-1:0]  column;
    logic                     last_group;
  } in_item_t;

  typedef struct packed {
    logic        [COL_W-1:0] out_column;
    logic signed [SUM_W-1:0] column_sum;
  } out_item_t;

  // one accumulate operation handed from front to back
  typedef struct packed {
    logic        [COL_W-1:0] column;
    logic signed [VAL_W-1:0] val;
    logic                    last;
  } acc_op_t;

  typedef enum logic {
    BK_CLEAR,
    BK_RUN
  } back_state_t;

endpackage
`default_nettype wire

[sv/tlma_front.sv]
// front end: holds the lookup table built from the activation group and
// turns weight code beats into accumulate ops; uses tlma_pkg
`default_nettype none
module tlma_front
  import tlma_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          push,
  output acc_op_t       op
);

  logic signed [ACT_W-1:0] tbl_r   [TBL_ENTRIES];
  logic signed [ACT_W-1:0] tbl_nxt [TBL_ENTRIES];

  // weighted term for one base-3 digit: 0 -> -a, 1 -> 0, 2 -> +a
  function automatic logic signed [VAL_W:0] term(input int digit,
                                                 input logic signed [ACT_W-1:0] a);
    logic signed [VAL_W:0] ax;
    ax = (VAL_W+1)'(a);
    if (digit == 0) begin
      return -ax;
    end else if (digit == 1) begin
      return '0;
    end
    return ax;
  endfunction

  function automatic logic signed [ACT_W-1:0] sat(input logic signed [VAL_W:0] s);
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    hi = (VAL_W+1)'(127);
    lo = -(VAL_W+1)'(128);
    if (s > hi) begin
      return ACT_W'(hi);
    end else if (s < lo) begin
      return ACT_W'(lo);
    end
    return ACT_W'(s);
  endfunction

  for (genvar g = 0; g < TBL_ENTRIES; g++) begin : g_tbl
    localparam int D0 = g % 3;
    localparam int D1 = (g / 3) % 3;
    localparam int D2 = g / 9;
    assign tbl_nxt[g] = sat(term(D0, item.act_first) + term(D1, item.act_second)
                            + term(D2, item.act_third));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL_ENTRIES; i++) tbl_r[i] <= '0;
    end else if (accept && item.kind == KIND_ACT) begin
      for (int i = 0; i < TBL_ENTRIES; i++) tbl_r[i] <= tbl_nxt[i];
    end
  end

  logic        [3:0]       idx;
  logic signed [ACT_W-1:0] entry;
  logic signed [VAL_W-1:0] ext;
  logic                    in_range;

  always_comb begin
    idx      = item.weight_code[3:0];
    // the two spare codes read as zero
    entry    = (32'(idx) < TBL_ENTRIES) ? tbl_r[idx] : '0;
    ext      = VAL_W'(entry);
    in_range = 32'(item.column) < 32'(COLUMNS);
    op.column = item.column;
    op.val    = item.weight_code[4] ? -ext : ext;
    op.last   = item.last_group;
    push      = accept && item.kind == KIND_WGT && in_range;
  end

endmodule
`default_nettype wire

[sv/tlma_queue.sv]
// short fifo of accumulate ops between front and back
// uses tlma_pkg for the op type and depth
`default_nettype none
module tlma_queue
  import tlma_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire acc_op_t push_op,
  input  wire logic    pop,
  output logic         full,
  output logic         nonempty,
  output acc_op_t      head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  acc_op_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  always_comb begin
    full       = cnt_r == (PW+1)'(QUEUE_DEPTH);
    nonempty   = cnt_r != '0;
    head       = slot_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_op;
  end

endmodule
`default_nettype wire

[sv/tlma_back.sv]
// back end: accumulator memory read-modify-write with forwarding,
// clearing pass after reset, and the result register; uses tlma_pkg
`default_nettype none
module tlma_back
  import tlma_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    op_valid,
  input  wire acc_op_t op,
  output logic         op_pop,
  output logic         busy,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_data
);

  localparam int DEPTH = (COLUMNS < (1 << COL_W)) ? COLUMNS : (1 << COL_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SUM_W-1:0] acc_mem [DEPTH];

  back_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic          clr_done;

  acc_op_t           s1_r;
  logic              s1_valid_r;
  logic [SUM_W-1:0]  rd_r;
  logic              fwd_r;
  logic [SUM_W-1:0]  fwd_data_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              out_free;
  logic              s1_adv;
  logic              fwd_nxt;
  logic [SUM_W-1:0]  base;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  wr_data;

  assign clr_done = clr_cnt_r == AW'(DEPTH - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: if (clr_done) state_nxt = BK_RUN;
      BK_RUN:   state_nxt = BK_RUN;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  always_comb begin
    unique case (state_r)
      BK_CLEAR: busy = 1'b1;
      BK_RUN:   busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_adv   = s1_valid_r && (!s1_r.last || out_free);
    op_pop   = op_valid && !busy && (!s1_valid_r || s1_adv);
    // read issued this edge misses the write of the op ahead on a match
    fwd_nxt  = op_pop && s1_adv && (op.column == s1_r.column);
    base     = fwd_r ? fwd_data_r : rd_r;
    sum      = base + SUM_W'(s1_r.val);
    wr_data  = s1_r.last ? '0 : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (busy) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (op_pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      // keep the forward select while the op waits in stage one
      if (op_pop) fwd_r <= fwd_nxt;
      if (s1_adv && s1_r.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) s1_r <= op;
    if (fwd_nxt) fwd_data_r <= wr_data;
    if (s1_adv && s1_r.last) begin
      out_data_r.out_column <= s1_r.column;
      out_data_r.column_sum <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      acc_mem[clr_cnt_r] <= '0;
    end else if (s1_adv) begin
      acc_mem[s1_r.column[AW-1:0]] <= wr_data;
    end
    if (op_pop) rd_r <= acc_mem[op.column[AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sv/ternary_lut_matvec_accumulate.sv]
// top level of the ternary lut matvec accumulator
// instantiates tlma_front, tlma_queue and tlma_back; uses tlma_pkg
//
// usage: the input channel (in_valid/in_stall/in_data) takes one beat per
// cycle while in_stall is low. an activation beat (kind 0) loads the
// three activations and rebuilds the 14-entry lookup table; it gives no
// result. a weight beat (kind 1) looks up the entry, negates it on bit 4
// of the code and adds it to the column accumulator; with last_group set
// the total comes out on out_valid/out_stall/out_data and the accumulator
// returns to zero. columns not below COLUMNS are dropped.
// throughput: one beat per cycle while no stall holds the flow, set by
// the single accumulator memory port pair (one read, one write per cycle,
// with forwarding between back-to-back beats on the same column).
// path: op queue, stage one, then the result register drives out_valid.
// reset: a clearing pass writes zero to each of the min(COLUMNS, 1024)
// accumulator entries, one per cycle; in_stall is high during it.
// receiver stall: the result register holds; the back end and then the
// 4-entry op queue fill, after which in_stall rises.
`default_nettype none
module ternary_lut_matvec_accumulate
  import tlma_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic    accept;
  logic    push;
  acc_op_t push_op;
  logic    q_full;
  logic    q_nonempty;
  acc_op_t q_head;
  logic    q_pop;
  logic    back_busy;

  assign in_stall = back_busy || q_full;
  assign accept   = in_valid && !in_stall;

  tlma_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .op     (push_op)
  );

  tlma_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_op  (push_op),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  tlma_back #(
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_nonempty),
    .op        (q_head),
    .op_pop    (q_pop),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// testbench for ternary_lut_matvec_accumulate: directed table, then random matvec traffic
// predicts from its copy of activations and column totals or a typed sum; uses tlma_pkg
module tb;
  import tlma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LUT_LAST = 13;               // highest index that holds a weighted sum
  localparam int NEG_BIT = 4;                 // weight code bit that negates the entry
  localparam logic [CODE_W-1:0] NEG = 5'h10;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    in_item_t                beat;
    bit                      typed;
    logic signed [SUM_W-1:0] typed_sum;
  } stim_row_t;

  typedef struct {
    bit                      typed;
    logic signed [SUM_W-1:0] sum;
  } beat_note_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // predictor state
  logic signed [ACT_W-1:0] grp_act [3];
  logic        [SUM_W-1:0] col_total [COLUMNS_DEF];

  out_item_t  sum_q[$];
  beat_note_t note_q[$];
  int         errors = 0;
  int         snd_pct, rcv_pct;
  int         hold_asked, hold_done, hold_left;

  ternary_lut_matvec_accumulate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [ACT_W-1:0] lut_entry(input logic [3:0] idx);
    int sum;
    int rest;
    int digit;
    sum = 0;
    rest = idx;
    if (idx > LUT_LAST) return '0;
    for (int k = 0; k < 3; k++) begin
      digit = rest % 3;
      sum += (digit - 1) * grp_act[k];
      rest = rest / 3;
    end
    if (sum > 127) sum = 127;
    if (sum < -128) sum = -128;
    return sum[ACT_W-1:0];
  endfunction

  function automatic void apply_beat(input in_item_t b, output bit fires, output out_item_t res);
    logic signed [ACT_W-1:0] entry;
    logic signed [SUM_W-1:0] val;
    fires = 1'b0;
    res = '0;
    if (b.kind == KIND_ACT) begin
      grp_act[0] = b.act_first;
      grp_act[1] = b.act_second;
      grp_act[2] = b.act_third;
      return;
    end
    if (b.column >= COLUMNS_DEF) return;
    entry = lut_entry(b.weight_code[3:0]);
    val = entry;
    if (b.weight_code[NEG_BIT]) val = -val;
    col_total[b.column] += val;
    if (!b.last_group) return;
    fires = 1'b1;
    res.out_column = b.column;
    res.column_sum = col_total[b.column];
    col_total[b.column] = '0;
  endfunction

  function automatic logic signed [ACT_W-1:0] rand_act();
    case ($urandom_range(9))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return '0;
      default: return ACT_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t mk_act(input logic signed [ACT_W-1:0] a0, a1, a2);
    in_item_t b;
    // fields of the other kind carry noise
    b = '0;
    b.kind = KIND_ACT;
    b.act_first = a0;
    b.act_second = a1;
    b.act_third = a2;
    b.weight_code = CODE_W'($urandom);
    b.column = COL_W'($urandom);
    b.last_group = 1'($urandom_range(1));
    return b;
  endfunction

  function automatic in_item_t mk_wgt(input logic [CODE_W-1:0] code, input logic [COL_W-1:0] col,
                                      input bit last);
    in_item_t b;
    b = '0;
    b.kind = KIND_WGT;
    b.act_first = ACT_W'($urandom);
    b.act_second = ACT_W'($urandom);
    b.act_third = ACT_W'($urandom);
    b.weight_code = code;
    b.column = col;
    b.last_group = last;
    return b;
  endfunction

  task automatic send_beat(input in_item_t b, input bit typed, input logic signed [SUM_W-1:0] tsum);
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    note_q.push_back('{typed, tsum});
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int groups;
    int ncols;
    bit drop_last;
    logic [COL_W-1:0] cols [6];
    logic [63:0] raw;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // noise beat: any kind, any field
        raw = {$urandom, $urandom};
        send_beat(raw[$bits(in_item_t)-1:0], 1'b0, '0);
        sent++;
      end else begin
        groups = $urandom_range(1, 4);
        ncols = $urandom_range(1, 6);
        drop_last = ($urandom_range(9) == 0);
        for (int c = 0; c < ncols; c++)
          cols[c] = ($urandom_range(9) < 7) ? COL_W'($urandom_range(15)) : COL_W'($urandom);
        for (int g = 0; g < groups; g++) begin
          send_beat(mk_act(rand_act(), rand_act(), rand_act()), 1'b0, '0);
          sent++;
          for (int c = 0; c < ncols; c++) begin
            send_beat(mk_wgt(CODE_W'($urandom_range(31)), cols[c],
                             (g == groups - 1) && !drop_last), 1'b0, '0);
            sent++;
          end
        end
      end
    end
  endtask

  // receiver: random stall, plus a long hold when asked
  initial begin
    out_stall = 1'b0;
    hold_done = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_asked != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rcv_pct != 0 && $urandom_range(99) < rcv_pct);
      end
    end
  end

  // predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    beat_note_t note;
    out_item_t  want;
    bit         fires;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        note = '{1'b0, '0};
        if (note_q.size() != 0) note = note_q.pop_front();
        apply_beat(in_data, fires, want);
        if (fires) begin
          if (note.typed) want.column_sum = note.sum;
          sum_q.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (sum_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got column %0d sum %0d",
                   $time, out_data.out_column, out_data.column_sum);
        end else begin
          want = sum_q.pop_front();
          if (out_data.out_column !== want.out_column) begin
            errors++;
            $display("%0t: out_column mismatch, expected %0d, got %0d",
                     $time, want.out_column, out_data.out_column);
          end
          if (out_data.column_sum !== want.column_sum) begin
            errors++;
            $display("%0t: column_sum mismatch (column %0d), expected %0d, got %0d",
                     $time, want.out_column, want.column_sum, out_data.column_sum);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    int guard;
    in_valid = 1'b0;
    in_data = '0;
    snd_pct = 0;
    rcv_pct = 0;
    hold_asked = 0;
    rst_n = 1'b0;
    foreach (grp_act[k]) grp_act[k] = '0;
    foreach (col_total[k]) col_total[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // weight beats before any activation see an all-zero table
    rows.push_back('{mk_wgt(5'd0, 10'd0, 1'b1), 1'b1, 0});
    rows.push_back('{mk_wgt(NEG | 5'd3, 10'd1, 1'b0), 1'b0, 0});
    rows.push_back('{mk_wgt(5'd13, 10'd1, 1'b1), 1'b1, 0});
    // saturation at both ends, negation, zero entries 14 and 15
    rows.push_back('{mk_act(8'sd127, 8'sd127, 8'sd127), 1'b0, 0});
    rows.push_back('{mk_wgt(5'd0, 10'd1023, 1'b1), 1'b1, -128});
    rows.push_back('{mk_wgt(NEG | 5'd0, 10'd1023, 1'b1), 1'b1, 128});
    rows.push_back('{mk_wgt(5'd14, 10'd5, 1'b1), 1'b1, 0});
    rows.push_back('{mk_wgt(NEG | 5'd15, 10'd5, 1'b1), 1'b1, 0});
    rows.push_back('{mk_act(-8'sd128, -8'sd128, -8'sd128), 1'b0, 0});
    rows.push_back('{mk_wgt(5'd0, 10'd2, 1'b0), 1'b0, 0});
    rows.push_back('{mk_wgt(5'd8, 10'd2, 1'b1), 1'b1, -1});
    // table indices 1 to 13 into one column
    rows.push_back('{mk_act(8'sd1, -8'sd2, 8'sd3), 1'b0, 0});
    for (int i = 1; i <= LUT_LAST; i++)
      rows.push_back('{mk_wgt(((i % 2) ? NEG : 5'd0) | CODE_W'(i), 10'd7, i == LUT_LAST),
                       1'b0, 0});
    foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].typed_sum);

    run_phase(420);
    // long receiver hold while beats keep coming, back-pressure reaches the input
    hold_asked++;
    for (int i = 0; i < 40; i++)
      send_beat(mk_wgt(CODE_W'($urandom), COL_W'($urandom), 1'b1), 1'b0, '0);
    snd_pct = 45;
    run_phase(420);
    snd_pct = 0;
    rcv_pct = 45;
    run_phase(420);
    snd_pct = 14;
    rcv_pct = 14;
    run_phase(420);
    in_valid <= 1'b0;

    guard = 0;
    while (sum_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sum_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, first expected column %0d sum %0d",
               $time, sum_q.size(), sum_q[0].out_column, sum_q[0].column_sum);
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tlma_pkg.sv
sv/tlma_front.sv
sv/tlma_queue.sv
sv/tlma_back.sv
sv/ternary_lut_matvec_accumulate.sv
tb/sv/tb.sv
